[src/rcc_pkg.sv]
// rcc_pkg: shared types and constants for the RC channel conditioner.
// Used by rcc_cfg_regs, rcc_stick_cond and rc_channel_conditioner_unit.
package rcc_pkg;

	localparam int unsigned RAW_W       = 11;
	localparam int unsigned STICK_W     = 12;
	localparam int unsigned BAND_W      = 8;
	localparam int unsigned STICK_N     = 4;
	localparam int unsigned SWITCH_N    = 4;
	localparam int unsigned THROTTLE_CH = 2;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned IN_DATA_W   = 88;
	localparam int unsigned OUT_DATA_W  = 56;

	localparam logic [RAW_W-1:0]  CENTRE_RST    = 11'd1500;
	localparam logic [RAW_W-1:0]  FLOOR_RST     = 11'd989;
	localparam logic [BAND_W-1:0] DEAD_BAND_RST = 8'd10;
	localparam logic [BAND_W-1:0] SLEW_RST      = 8'd30;
	localparam logic [RAW_W-1:0]  SWITCH_RST    = 11'd1250;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STICK_CENTRE     = 3'd0,
		REG_THROTTLE_FLOOR   = 3'd1,
		REG_DEAD_BAND        = 3'd2,
		REG_SLEW_STEP        = 3'd3,
		REG_SWITCH_THRESHOLD = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [RAW_W-1:0]  stick_centre;
		logic [RAW_W-1:0]  throttle_floor;
		logic [BAND_W-1:0] dead_band;
		logic [BAND_W-1:0] slew_step;
		logic [RAW_W-1:0]  switch_threshold;
	} cfg_t;

endpackage

[src/rcc_cfg_regs.sv]
// rcc_cfg_regs: configuration register file of the RC channel conditioner.
// Depends on rcc_pkg.
module rcc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcc_pkg::RAW_W-1:0]     cfg_data,
	output rcc_pkg::cfg_t                 cfg
);

	rcc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_centre     <= rcc_pkg::CENTRE_RST;
			cfg_q.throttle_floor   <= rcc_pkg::FLOOR_RST;
			cfg_q.dead_band        <= rcc_pkg::DEAD_BAND_RST;
			cfg_q.slew_step        <= rcc_pkg::SLEW_RST;
			cfg_q.switch_threshold <= rcc_pkg::SWITCH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rcc_pkg::cfg_reg_t'(cfg_index))
				rcc_pkg::REG_STICK_CENTRE:     cfg_q.stick_centre     <= cfg_data;
				rcc_pkg::REG_THROTTLE_FLOOR:   cfg_q.throttle_floor   <= cfg_data;
				rcc_pkg::REG_DEAD_BAND:        cfg_q.dead_band        <= cfg_data[rcc_pkg::BAND_W-1:0];
				rcc_pkg::REG_SLEW_STEP:        cfg_q.slew_step        <= cfg_data[rcc_pkg::BAND_W-1:0];
				rcc_pkg::REG_SWITCH_THRESHOLD: cfg_q.switch_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[src/rcc_stick_cond.sv]
// rcc_stick_cond: offset, deadband and slew clamp for one stick channel.
// Depends on rcc_pkg; purely combinational.
module rcc_stick_cond (
	input  logic [rcc_pkg::RAW_W-1:0]          raw,
	input  logic [rcc_pkg::RAW_W-1:0]          offset,
	input  logic                               throttle_mode,
	input  logic [rcc_pkg::BAND_W-1:0]         dead_band,
	input  logic [rcc_pkg::BAND_W-1:0]         slew_step,
	input  logic signed [rcc_pkg::STICK_W-1:0] prev,
	output logic signed [rcc_pkg::STICK_W-1:0] value
);

	localparam int unsigned W = rcc_pkg::STICK_W + 1;

	logic signed [W-1:0] diff;
	logic signed [W-1:0] db;
	logic signed [W-1:0] slew;
	logic signed [W-1:0] outer;
	logic signed [W-1:0] prev_x;
	logic signed [W-1:0] hi;
	logic signed [W-1:0] lo;
	logic signed [W-1:0] banded;
	logic signed [W-1:0] limited;
	logic                in_band;

	always_comb begin
		diff   = $signed({2'b00, raw}) - $signed({2'b00, offset});
		db     = $signed({{(W - rcc_pkg::BAND_W){1'b0}}, dead_band});
		slew   = $signed({{(W - rcc_pkg::BAND_W){1'b0}}, slew_step});
		outer  = db + slew;
		prev_x = $signed({prev[rcc_pkg::STICK_W-1], prev});
		hi     = prev_x + slew;
		lo     = prev_x - slew;

		if (throttle_mode) begin
			in_band = diff < db;
		end else begin
			in_band = (diff < db) && (diff > -db);
		end
		banded = in_band ? '0 : diff;

		limited = banded;
		if (banded > outer || banded < -outer) begin
			priority if (banded > hi) begin
				limited = hi;
			end else if (banded < lo) begin
				limited = lo;
			end else begin
				limited = banded;
			end
		end
		value = limited[rcc_pkg::STICK_W-1:0];
	end

endmodule

[src/rc_channel_conditioner_unit.sv]
// rc_channel_conditioner_unit: top level of the RC channel conditioner.
// Depends on rcc_pkg, rcc_cfg_regs and rcc_stick_cond.
//
// Usage:
//   s_* carries one frame of eight 11-bit raw pulse widths per transfer.
//   m_* carries one conditioned result per frame: four signed 12-bit stick
//   values and four switch bits.
//   cfg_* writes one register per transfer (always ready); write only while
//   no frame is in flight.
// Path: input stage register, then conditioning, then result register.
// Throughput: one frame per cycle while m_tready is high; the input stage
// register and the result register form a two-entry pipeline, so s_tready
// stays high while a result waits if the input stage is free or moving.
// The previous stick outputs used by the slew clamp live in the result
// register itself and update in frame order.
// Reset: config returns to its defaults, previous outputs clear to zero,
// both stages empty.
// Stall: with m_tready low the result holds; one more frame is taken into
// the input stage, then s_tready drops until the result is taken.
module rc_channel_conditioner_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// fields low to high: roll_raw, pitch_raw, throttle_raw, yaw_raw,
	// switch_a_raw, switch_b_raw, switch_c_raw, switch_d_raw
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rcc_pkg::IN_DATA_W-1:0]  s_tdata,
	// fields low to high: roll_out, pitch_out, throttle_out, yaw_out,
	// switch_a_on, switch_b_on, switch_c_on, switch_d_on, 4 zero bits
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rcc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcc_pkg::RAW_W-1:0]      cfg_data
);

	localparam int unsigned RW = rcc_pkg::RAW_W;
	localparam int unsigned SW = rcc_pkg::STICK_W;

	rcc_pkg::cfg_t cfg;

	logic                          valid_s1;
	logic [rcc_pkg::IN_DATA_W-1:0] data_s1;
	logic                          out_valid_q;
	logic signed [SW-1:0]          stick_q   [rcc_pkg::STICK_N];
	logic signed [SW-1:0]          stick_new [rcc_pkg::STICK_N];
	logic [rcc_pkg::SWITCH_N-1:0]  switch_q;
	logic [rcc_pkg::SWITCH_N-1:0]  switch_new;
	logic                          advance;

	rcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

	for (genvar i = 0; i < rcc_pkg::STICK_N; i++) begin : g_stick
		rcc_stick_cond u_stick (
			.raw           (data_s1[i*RW +: RW]),
			.offset        ((i == rcc_pkg::THROTTLE_CH) ? cfg.throttle_floor : cfg.stick_centre),
			.throttle_mode (i == rcc_pkg::THROTTLE_CH),
			.dead_band     (cfg.dead_band),
			.slew_step     (cfg.slew_step),
			.prev          (stick_q[i]),
			.value         (stick_new[i])
		);
	end

	for (genvar j = 0; j < rcc_pkg::SWITCH_N; j++) begin : g_switch
		assign switch_new[j] = data_s1[(rcc_pkg::STICK_N + j)*RW +: RW] > cfg.switch_threshold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			switch_q    <= '0;
			for (int k = 0; k < rcc_pkg::STICK_N; k++) begin
				stick_q[k] <= '0;
			end
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				switch_q <= switch_new;
				for (int k = 0; k < rcc_pkg::STICK_N; k++) begin
					stick_q[k] <= stick_new[k];
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, switch_q, stick_q[3], stick_q[2], stick_q[1], stick_q[0]};

	// input stage only blocks when both stages are full and the sink stalls
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("s_tready low without a full, stalled pipeline");

	a_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1) |=> out_valid_q)
		else $error("frame in input stage lost on advance");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1)))
		else $error("input stage changed while blocked");

	a_stick_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (stick_q[0] != 12'sh800 && stick_q[1] != 12'sh800 &&
			stick_q[2] != 12'sh800 && stick_q[3] != 12'sh800))
		else $error("stick output outside -2047..2047");

endmodule

[tb/tb.sv]
// tb: self-checking testbench for rc_channel_conditioner_unit.
// Predicts each conditioned frame from its own model of deadband, slew clamp and
// switch thresholds, driven under random idling. Depends on rcc_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rcc_pkg::*;

	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RAW_MAX       = (1 << RAW_W) - 1;
	localparam int PHASE_N       = 8;
	localparam int HALF_PHASE    = 100;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [RAW_W-1:0]       cfg_data = '0;

	cfg_t live_cfg = '{CENTRE_RST, FLOOR_RST, DEAD_BAND_RST, SLEW_RST, SWITCH_RST};
	logic signed [STICK_W-1:0] last_stick [STICK_N] = '{default: '0};

	logic [IN_DATA_W-1:0]  frame_q [$];
	logic [OUT_DATA_W-1:0] expected_q [$];
	int pushed_count = 0;
	int accepted_count = 0;
	int errors = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	string stick_name [STICK_N] = '{"roll_out", "pitch_out", "throttle_out", "yaw_out"};
	string switch_name [SWITCH_N] = '{"switch_a_on", "switch_b_on", "switch_c_on", "switch_d_on"};

	rc_channel_conditioner_unit DUT (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [OUT_DATA_W-1:0] condition_frame(input logic [IN_DATA_W-1:0] frame);
		logic [OUT_DATA_W-1:0] res;
		int v, band, step, outer, prev;
		res = '0;
		band = int'(live_cfg.dead_band);
		step = int'(live_cfg.slew_step);
		outer = band + step;
		for (int i = 0; i < STICK_N; i++) begin
			if (i == THROTTLE_CH) begin
				v = int'(frame[i*RAW_W +: RAW_W]) - int'(live_cfg.throttle_floor);
				if (v < band) v = 0;
			end else begin
				v = int'(frame[i*RAW_W +: RAW_W]) - int'(live_cfg.stick_centre);
				if (v < band && v > -band) v = 0;
			end
			prev = int'(last_stick[i]);
			// clamp only outside the combined deadband + slew band
			if (v > outer || v < -outer) begin
				if (v > prev + step) v = prev + step;
				else if (v < prev - step) v = prev - step;
			end
			last_stick[i] = v[STICK_W-1:0];
			res[i*STICK_W +: STICK_W] = v[STICK_W-1:0];
		end
		for (int i = 0; i < SWITCH_N; i++)
			res[STICK_N*STICK_W + i] = frame[(STICK_N+i)*RAW_W +: RAW_W] > live_cfg.switch_threshold;
		return res;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_frame(
		input logic [RAW_W-1:0] roll, pitch, throttle, yaw, sw_a, sw_b, sw_c, sw_d);
		return {sw_d, sw_c, sw_b, sw_a, yaw, throttle, pitch, roll};
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw(input int base, input int span);
		int v;
		case ($urandom_range(7))
			0, 1: v = int'($urandom_range(RAW_MAX));
			2: v = $urandom_range(1) ? RAW_MAX : 0;
			default: v = base + int'($urandom_range(2 * span)) - span;
		endcase
		if (v < 0) v = 0;
		if (v > RAW_MAX) v = RAW_MAX;
		return v[RAW_W-1:0];
	endfunction

	function automatic logic [IN_DATA_W-1:0] random_frame();
		int span, ctr, flr, thr;
		span = int'(live_cfg.dead_band) + int'(live_cfg.slew_step) + 16;
		ctr = int'(live_cfg.stick_centre);
		flr = int'(live_cfg.throttle_floor);
		thr = int'(live_cfg.switch_threshold);
		return pack_frame(pick_raw(ctr, span), pick_raw(ctr, span), pick_raw(flr, span),
			pick_raw(ctr, span), pick_raw(thr, 4), pick_raw(thr, 4), pick_raw(thr, 4),
			pick_raw(thr, 4));
	endfunction

	task automatic queue_frame(input logic [IN_DATA_W-1:0] frame);
		frame_q.push_back(frame);
		pushed_count++;
	endtask

	task automatic drain();
		while (accepted_count != pushed_count || expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_STICK_CENTRE:     live_cfg.stick_centre = val;
			REG_THROTTLE_FLOOR:   live_cfg.throttle_floor = val;
			REG_DEAD_BAND:        live_cfg.dead_band = val[BAND_W-1:0];
			REG_SLEW_STEP:        live_cfg.slew_step = val[BAND_W-1:0];
			REG_SWITCH_THRESHOLD: live_cfg.switch_threshold = val;
			default: ;
		endcase
	endtask

	task automatic check_result(input logic [OUT_DATA_W-1:0] got);
		logic [OUT_DATA_W-1:0] want;
		logic signed [STICK_W-1:0] want_s, got_s;
		if (expected_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
		end else begin
			want = expected_q.pop_front();
			for (int i = 0; i < STICK_N; i++) begin
				want_s = want[i*STICK_W +: STICK_W];
				got_s = got[i*STICK_W +: STICK_W];
				if (got_s !== want_s) begin
					errors++;
					$display("%0t: %s expected %0d, actual %0d", $time, stick_name[i], want_s, got_s);
				end
			end
			for (int i = 0; i < SWITCH_N; i++) begin
				if (got[STICK_N*STICK_W + i] !== want[STICK_N*STICK_W + i]) begin
					errors++;
					$display("%0t: %s expected %b, actual %b", $time, switch_name[i],
						want[STICK_N*STICK_W + i], got[STICK_N*STICK_W + i]);
				end
			end
			if (got[OUT_DATA_W-1:STICK_N*STICK_W+SWITCH_N] !== '0) begin
				errors++;
				$display("%0t: pad bits expected 0, actual %b", $time,
					got[OUT_DATA_W-1:STICK_N*STICK_W+SWITCH_N]);
			end
		end
	endtask

	// frame driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_q.push_back(condition_frame(s_tdata));
				accepted_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata <= frame_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) check_result(m_tdata);
			m_tready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// default config: extremes, deadband and slew window edges, switch threshold edges
		queue_frame(pack_frame(11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0));
		queue_frame(pack_frame('1, '1, '1, '1, '1, '1, '1, '1));
		queue_frame(pack_frame(11'd1500, 11'd1500, 11'd989, 11'd1500,
			11'd1250, 11'd1251, 11'd1250, 11'd1251));
		queue_frame(pack_frame(11'd1509, 11'd1510, 11'd999, 11'd1491,
			11'd1251, 11'd1250, 11'd1251, 11'd1250));
		queue_frame(pack_frame(11'd1490, 11'd1540, 11'd998, 11'd1541,
			'1, 11'd0, '1, 11'd0));
		queue_frame(pack_frame(11'd1460, 11'd1459, 11'd1029, 11'd1540,
			11'd0, '1, 11'd0, '1));
		repeat (3) queue_frame(pack_frame('1, 11'd0, '1, 11'd0,
			11'd1251, 11'd1251, 11'd1251, 11'd1251));
		queue_frame(pack_frame(11'd0, '1, 11'd1030, '1, 11'd1249, 11'd1249, 11'd1249, 11'd1249));
		drain();

		// zero slew step: window collapses onto the previous output
		write_reg(REG_SLEW_STEP, 11'd0);
		write_reg(REG_SPARE_FIRST, 11'd0);
		write_reg(REG_SPARE_LAST, '1);
		queue_frame(pack_frame('1, 11'd0, '1, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0));
		queue_frame(pack_frame(11'd1545, 11'd1455, 11'd1000, 11'd1500, '1, '1, '1, '1));
		queue_frame(pack_frame(11'd1505, 11'd1495, 11'd995, 11'd1510, 11'd0, '1, 11'd0, '1));
		drain();

		// upper data bits beyond the register width are dropped: deadband becomes zero
		write_reg(REG_DEAD_BAND, 11'h700);
		queue_frame(pack_frame(11'd1501, 11'd1499, 11'd988, 11'd1500, 11'd0, 11'd0, 11'd0, 11'd0));
		queue_frame(pack_frame(11'd1500, 11'd1500, 11'd989, 11'd0, '1, '1, '1, '1));
		queue_frame(pack_frame(11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0));
		drain();

		for (int p = 0; p < PHASE_N; p++) begin
			case (p)
				0: begin
					write_reg(REG_STICK_CENTRE, CENTRE_RST);
					write_reg(REG_THROTTLE_FLOOR, FLOOR_RST);
					write_reg(REG_DEAD_BAND, 11'(DEAD_BAND_RST));
					write_reg(REG_SLEW_STEP, 11'(SLEW_RST));
					write_reg(REG_SWITCH_THRESHOLD, SWITCH_RST);
				end
				1: begin
					write_reg(REG_STICK_CENTRE, 11'd0);
					write_reg(REG_THROTTLE_FLOOR, 11'd0);
					write_reg(REG_DEAD_BAND, 11'd0);
					write_reg(REG_SLEW_STEP, 11'd0);
					write_reg(REG_SWITCH_THRESHOLD, 11'd0);
				end
				2: begin
					write_reg(REG_STICK_CENTRE, '1);
					write_reg(REG_THROTTLE_FLOOR, '1);
					write_reg(REG_DEAD_BAND, '1);
					write_reg(REG_SLEW_STEP, '1);
					write_reg(REG_SWITCH_THRESHOLD, '1);
				end
				default: begin
					write_reg(REG_STICK_CENTRE, 11'($urandom_range(RAW_MAX)));
					write_reg(REG_THROTTLE_FLOOR, 11'($urandom_range(RAW_MAX)));
					write_reg(REG_DEAD_BAND, 11'($urandom_range(RAW_MAX)));
					write_reg(REG_SLEW_STEP, $urandom_range(1) ? 11'($urandom_range(8))
						: 11'($urandom_range(RAW_MAX)));
					write_reg(REG_SWITCH_THRESHOLD, 11'($urandom_range(RAW_MAX)));
					write_reg(3'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
						11'($urandom_range(RAW_MAX)));
				end
			endcase
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			repeat (HALF_PHASE) queue_frame(random_frame());
			// sender holds off until every result of the first half is back
			drain();
			repeat (HALF_PHASE) queue_frame(random_frame());
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
